### src/swrm_pkg.sv
// Shared package for the stack with running median.
// Holds the command codes and the control struct that drives the sorted chain.
// No dependencies.
package swrm_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Per-cycle control broadcast to every cell of the sorted chain
  typedef struct packed {
    logic ins;  // insert the broadcast key in order
    logic del;  // remove one copy of the broadcast key
  } cell_ctl_t;

endpackage

### src/swrm_cell.sv
// One cell of the sorted key chain.
// Holds a single key and shifts toward a neighbor on insert or delete.
// Depends on swrm_pkg.
module swrm_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                  clk,
  input  swrm_pkg::cell_ctl_t   ctl,
  input  logic [KEY_BITS-1:0]   key,
  input  logic                  valid,
  input  logic                  left_gt,
  input  logic [KEY_BITS-1:0]   left_val,
  input  logic [KEY_BITS-1:0]   right_val,
  output logic                  gt,
  output logic [KEY_BITS-1:0]   val
);

  logic ge;

  // An empty cell counts as larger than any key
  always_comb begin
    gt = !valid || (val > key);
    ge = val >= key;
  end

  // Insert: cells above the key move up one place; the first of them takes the key.
  // Delete: cells at or above the key take the value from their right neighbor.
  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      val <= left_gt ? left_val : key;
    end else if (ctl.del && valid && ge) begin
      val <= right_val;
    end
  end

endmodule

### src/swrm_lifo.sv
// Push-order key store for the stack with running median.
// One write port and one registered read port.
// No dependencies.
module swrm_lifo #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [KEY_BITS-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [KEY_BITS-1:0]       rdata
);

  logic [KEY_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/stack_with_running_median.sv
// Stack with running median: a LIFO of keys plus a sorted chain of cells.
// Each item has an accept cycle that reads the stack top; in the next cycle the
// item inserts, deletes or taps the median in the chain. busy is high then.
// No new item is taken while busy; a result shows on done for one cycle
// right after the execute cycle and cannot be stalled.
// Synchronous active-high reset empties the stack; key storage is not cleared.
module stack_with_running_median #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic [KEY_BITS-1:0]  push_key,
  output logic                 done,
  output logic                 is_invalid,
  output logic [KEY_BITS-1:0]  result_key
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state;
  logic [CNT_W-1:0]     count;
  logic [1:0]           cmd_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [KEY_BITS-1:0]  top_key;
  logic [KEY_BITS-1:0]  bcast_key;
  logic [KEY_BITS-1:0]  med_key;
  logic [CNT_W:0]       med_rank;
  logic [IDX_W-1:0]     med_idx;
  logic [IDX_W-1:0]     top_idx;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 do_push;
  logic                 do_pop;
  swrm_pkg::cell_ctl_t  ctl;

  logic [KEY_BITS-1:0]  val_w [DEPTH];
  logic                 gt_w  [DEPTH];

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // Execute-cycle decode
  always_comb begin
    do_push   = busy && (cmd_q == swrm_pkg::CMD_PUSH) && !full;
    do_pop    = busy && (cmd_q == swrm_pkg::CMD_POP) && !empty;
    ctl.ins   = do_push;
    ctl.del   = do_pop;
    bcast_key = do_pop ? top_key : key_q;
    top_idx   = IDX_W'(count - CNT_W'(1));
    // lower median sits at rank ceil(n/2), index one less
    med_rank  = ({1'b0, count} + (CNT_W + 1)'(1)) >> 1;
    med_idx   = IDX_W'(med_rank - (CNT_W + 1)'(1));
    med_key   = val_w[med_idx];
  end

  // Item capture and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          if (do_push) begin
            count <= count + CNT_W'(1);
          end else if (do_pop) begin
            count <= count - CNT_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item payload latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      key_q <= push_key;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && (cmd_q == swrm_pkg::CMD_POP || cmd_q == swrm_pkg::CMD_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      is_invalid <= empty;
      if (empty) begin
        result_key <= '0;
      end else if (cmd_q == swrm_pkg::CMD_POP) begin
        result_key <= top_key;
      end else begin
        result_key <= med_key;
      end
    end
  end

  // Push-order store; the top is read during the accept cycle
  swrm_lifo #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_lifo (
    .clk   (clk),
    .we    (do_push),
    .waddr (IDX_W'(count)),
    .wdata (key_q),
    .raddr (top_idx),
    .rdata (top_key)
  );

  // Sorted chain of cells, ascending from cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                valid_c;
    logic                left_gt_c;
    logic [KEY_BITS-1:0] left_val_c;
    logic [KEY_BITS-1:0] right_val_c;

    assign valid_c = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_gt_c  = 1'b0;
      assign left_val_c = bcast_key;
    end else begin : g_inner
      assign left_gt_c  = gt_w[i-1];
      assign left_val_c = val_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val_c = val_w[i];
    end else begin : g_mid
      assign right_val_c = val_w[i+1];
    end

    swrm_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (bcast_key),
      .valid     (valid_c),
      .left_gt   (left_gt_c),
      .left_val  (left_val_c),
      .right_val (right_val_c),
      .gt        (gt_w[i]),
      .val       (val_w[i])
    );
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_done_follows_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result without an execute cycle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_invalid) |-> (result_key == '0))
    else $error("invalid result carries a key");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && !$past(busy)))
    else $error("accepted item did not enter execute");

  a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (val_w[0] <= val_w[1]))
    else $error("sorted chain out of order");

endmodule

### test/tb_stack_with_running_median.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_with_running_median (push, pop, median query).
// Scoreboard class predicts each result from its own stack and sorted copy.
// Depends on swrm_pkg and the RTL top module.

module tb_stack_with_running_median;

  localparam int STACK_DEPTH  = 64;
  localparam int KEY_W        = 16;
  localparam int N_ITEMS      = 1300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Stimulus mix of a burst
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} burst_mix_t;

  typedef struct packed {
    logic             invalid;
    logic [KEY_W-1:0] key;
  } stack_result_t;

  // Predicts pops and medians and checks them in order
  class median_stack_scoreboard;
    logic [KEY_W-1:0] push_order[$];
    logic [KEY_W-1:0] ascending[$];
    stack_result_t    pending_results[$];
    int errors;
    int effective_items;
    int pushes, pops, queries, invalids, full_pushes, max_fill;

    function int fill();
      return push_order.size();
    endfunction

    // Apply one accepted item; queue the result it will cause, if any
    function void note_item(logic [1:0] op, logic [KEY_W-1:0] key);
      stack_result_t r;
      int pos;
      r = '0;
      pos = 0;
      case (op)
        swrm_pkg::CMD_PUSH: begin
          if (push_order.size() >= STACK_DEPTH) begin
            full_pushes++;
            return;
          end
          push_order.push_back(key);
          while (pos < ascending.size() && ascending[pos] <= key) pos++;
          ascending.insert(pos, key);
          pushes++;
          effective_items++;
          if (push_order.size() > max_fill) max_fill = push_order.size();
        end
        swrm_pkg::CMD_POP: begin
          if (push_order.size() == 0) begin
            r.invalid = 1'b1;
            invalids++;
          end else begin
            r.key = push_order.pop_back();
            // drop one copy only, duplicates stay
            while (ascending[pos] != r.key) pos++;
            ascending.delete(pos);
          end
          pops++;
          effective_items++;
          pending_results.push_back(r);
        end
        swrm_pkg::CMD_QUERY: begin
          if (ascending.size() == 0) begin
            r.invalid = 1'b1;
            invalids++;
          end else begin
            // lower median: rank ceil(n/2)
            r.key = ascending[(ascending.size() + 1) / 2 - 1];
          end
          queries++;
          effective_items++;
          pending_results.push_back(r);
        end
        default: ;  // unused code is ignored
      endcase
    endfunction

    function void check_result(logic invalid, logic [KEY_W-1:0] key);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result is_invalid=%0b result_key=%h", $time, invalid, key);
        return;
      end
      want = pending_results.pop_front();
      if (invalid !== want.invalid) begin
        errors++;
        $display("%0t: is_invalid mismatch: expected %0b, actual %0b",
                 $time, want.invalid, invalid);
      end
      if (key !== want.key) begin
        errors++;
        $display("%0t: result_key mismatch: expected %h, actual %h", $time, want.key, key);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] push_key;
  logic             done;
  logic             is_invalid;
  logic [KEY_W-1:0] result_key;

  median_stack_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;
  // sender idle share per phase; the third phase stands for receiver stall,
  // which this block has no way to apply
  int idle_by_phase[4] = '{0, 74, 0, 22};

  stack_with_running_median #(
    .DEPTH   (STACK_DEPTH),
    .KEY_BITS(KEY_W)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .push_key  (push_key),
    .done      (done),
    .is_invalid(is_invalid),
    .result_key(result_key)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Result check and watchdog
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(is_invalid, result_key);
    if (rst || done || (start && !busy)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no item or result for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Drive one item after an optional idle gap; returns just after a falling edge
  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    cmd      <= op;
    push_key <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, key);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return KEY_W'($urandom_range(7));  // dense range, many duplicates
    if (sel < 35) return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
    return KEY_W'($urandom());
  endfunction

  function automatic logic [1:0] pick_cmd(burst_mix_t mix, int level);
    int sel;
    sel = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (level < STACK_DEPTH) return swrm_pkg::CMD_PUSH;
        // full: keep pushing some to hit the overflow case
        if (sel < 40) return swrm_pkg::CMD_PUSH;
        if (sel < 70) return swrm_pkg::CMD_QUERY;
        return swrm_pkg::CMD_POP;
      end
      MIX_DRAIN: begin
        if (sel < 60) return swrm_pkg::CMD_POP;
        if (sel < 85) return swrm_pkg::CMD_QUERY;
        if (sel < 95) return swrm_pkg::CMD_PUSH;
        return CMD_UNUSED;
      end
      default: begin
        if (sel < 45) return swrm_pkg::CMD_PUSH;
        if (sel < 72) return swrm_pkg::CMD_POP;
        if (sel < 95) return swrm_pkg::CMD_QUERY;
        return CMD_UNUSED;
      end
    endcase
  endfunction

  initial begin
    burst_mix_t mix;
    int         burst_left;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = swrm_pkg::CMD_PUSH;
    push_key     = '0;
    idle_pct     = 0;
    quiet_cycles = 0;
    mix          = MIX_BALANCED;
    burst_left   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty stack, extremes, duplicates, unused code
    send_item(swrm_pkg::CMD_QUERY, 16'h1234);
    send_item(swrm_pkg::CMD_POP, 16'hFFFF);
    send_item(CMD_UNUSED, 16'h0001);
    send_item(swrm_pkg::CMD_PUSH, 16'hFFFF);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(swrm_pkg::CMD_PUSH, 16'h0000);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(swrm_pkg::CMD_PUSH, 16'h8000);
    send_item(swrm_pkg::CMD_PUSH, 16'h8000);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(swrm_pkg::CMD_PUSH, 16'h0005);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(CMD_UNUSED, 16'hFFFF);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_POP, 16'h0000);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);
    send_item(swrm_pkg::CMD_PUSH, 16'hAAAA);
    send_item(swrm_pkg::CMD_PUSH, 16'h5555);
    send_item(swrm_pkg::CMD_QUERY, 16'h0000);

    // Random bursts: fill to full, drain past empty, or mixed
    while (sb.effective_items < N_ITEMS) begin
      if (burst_left == 0) begin
        mix        = burst_mix_t'($urandom_range(2));
        burst_left = $urandom_range(20, 70);
      end
      idle_pct = idle_by_phase[(sb.effective_items / 150) % 4];
      send_item(pick_cmd(mix, sb.fill()), pick_key());
      burst_left--;
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pushes, %0d pops, %0d median queries, %0d on an empty stack,",
             sb.pushes, sb.pops, sb.queries, sb.invalids);
    $display("%0d pushes onto a full stack, peak fill %0d; %0d mismatches.",
             sb.full_pushes, sb.max_fill, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
